// File: sv/gbs_pkg.sv
package gbs_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 16;
    localparam int SQ_W       = 24;
    localparam int THR_W      = 18;
    localparam int TRN_W      = 9;
    localparam int WGT_W      = 12;
    localparam int PROD_W     = 37;
    localparam int VAR_W      = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int MAX_PIXELS_DEF = 262144;
    localparam int MAX_TRAIN_DEF  = 256;

    localparam logic [TRN_W-1:0] TRAIN_RST  = 9'd200;
    localparam logic [WGT_W-1:0] WEIGHT_RST = 12'd307;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

    // what a pixel does in its frame
    typedef enum logic [3:0] {
        K_FIRST = 4'b0001,
        K_ACC   = 4'b0010,
        K_BUILD = 4'b0100,
        K_DET   = 4'b1000
    } t_kind;

endpackage

// File: sv/gbs_div.sv
module gbs_div #(
    parameter int NW = 16,
    parameter int DW = 9,
    parameter int QW = 8,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [QW:0]   r_vld;
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_lo  [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic          r_sat [QW+1];
    logic [TW-1:0] r_tag [QW+1];

    logic [CW-1:0] n_hi;
    logic          n_sat;

    assign n_hi  = CW'(i_num[NW-1:QW]);
    assign n_sat = n_hi >= CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num[NW-1:QW]);
            r_lo[0]  <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_sat[0] <= n_sat;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] w_t;
        logic [DW:0] w_d;
        logic        w_ge;
        assign w_t  = {r_rem[k-1], r_lo[k-1][QW-k]};
        assign w_d  = w_t - {1'b0, r_den[k-1]};
        assign w_ge = w_t >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_d[DW-1:0] : w_t[DW-1:0];
                r_lo[k]  <= r_lo[k-1];
                r_quo[k] <= {r_quo[k-1][QW-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_quo = r_sat[QW] ? '1 : r_quo[QW];
    assign o_tag = r_tag[QW];

endmodule

// File: sv/gbs_store.sv
module gbs_store #(
    parameter int MAX_PIXELS = 262144,
    parameter int PW         = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  gbs_pkg::t_kind          i_kind,
    input  logic [PW-1:0]           i_pos,
    input  logic [gbs_pkg::PIX_W-1:0] i_px,
    input  logic                    i_eof,
    input  logic                    i_mwe,
    input  logic [PW-1:0]           i_mpos,
    input  logic [gbs_pkg::PIX_W-1:0] i_mean,
    input  logic [gbs_pkg::THR_W-1:0] i_thr,
    output logic                    o_vld,
    output gbs_pkg::t_kind          o_kind,
    output logic [PW-1:0]           o_pos,
    output logic [gbs_pkg::PIX_W-1:0] o_px,
    output logic                    o_eof,
    output logic [gbs_pkg::SUM_W-1:0] o_sum,
    output logic [gbs_pkg::SQ_W-1:0]  o_sq,
    output logic [gbs_pkg::PIX_W-1:0] o_mean,
    output logic [gbs_pkg::THR_W-1:0] o_thr
);
    import gbs_pkg::*;

    logic [SUM_W-1:0] mem_sum  [MAX_PIXELS];
    logic [SQ_W-1:0]  mem_sq   [MAX_PIXELS];
    logic [PIX_W-1:0] mem_mean [MAX_PIXELS];
    logic [THR_W-1:0] mem_thr  [MAX_PIXELS];

    logic             r_vld;
    t_kind            r_kind;
    logic [PW-1:0]    r_pos;
    logic [PIX_W-1:0] r_px;
    logic             r_eof;
    logic [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]  r_sq;
    logic [PIX_W-1:0] r_mean;
    logic [THR_W-1:0] r_thr;

    logic [2*PIX_W-1:0] n_pp;
    logic [SUM_W-1:0]   n_sum;
    logic [SQ_W-1:0]    n_sq;
    logic               n_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind <= i_kind;
            r_pos  <= i_pos;
            r_px   <= i_px;
            r_eof  <= i_eof;
            r_sum  <= mem_sum[i_pos];
            r_sq   <= mem_sq[i_pos];
            r_mean <= mem_mean[i_pos];
            r_thr  <= mem_thr[i_pos];
        end
    end

    assign n_pp  = r_px * r_px;
    assign n_sum = (r_kind == K_FIRST) ? SUM_W'(r_px) : r_sum + SUM_W'(r_px);
    assign n_sq  = (r_kind == K_FIRST) ? SQ_W'(n_pp) : r_sq + SQ_W'(n_pp);
    assign n_wr  = r_vld && (r_kind == K_FIRST || r_kind == K_ACC);

    always_ff @(posedge i_clk) begin
        if (i_en && n_wr) begin
            mem_sum[r_pos] <= n_sum;
            mem_sq[r_pos]  <= n_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_mwe) begin
            mem_mean[i_mpos] <= i_mean;
            mem_thr[i_mpos]  <= i_thr;
        end
    end

    assign o_vld  = r_vld;
    assign o_kind = r_kind;
    assign o_pos  = r_pos;
    assign o_px   = r_px;
    assign o_eof  = r_eof;
    assign o_sum  = r_sum;
    assign o_sq   = r_sq;
    assign o_mean = r_mean;
    assign o_thr  = r_thr;

endmodule

// File: sv/gaussian_background_subtractor.sv
// Single-Gaussian background subtraction on a gray pixel stream. The first
// train_frames frames build per-pixel sums, the next frame turns them into a
// mean and a threshold (weight_q8 times variance, Q4.8), and every frame after
// that gives one foreground beat per pixel. A pixel is taken every clock
// unless the output stalls or a frame start is held back; the pipeline is 33
// registers deep (the store read, two unrolled restoring dividers of 9 and 19
// stages and four multiply stages) ahead of the output register. The first
// pixel of a frame waits until training or model writes still in the pipeline
// have reached the stores. No output comes out during training or the model
// frame. Configure only while idle.
module gaussian_background_subtractor #(
    parameter int MAX_PIXELS = gbs_pkg::MAX_PIXELS_DEF,
    parameter int MAX_TRAIN  = gbs_pkg::MAX_TRAIN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [gbs_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_end_of_frame,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_foreground,
    output logic                           o_frame_end
);
    import gbs_pkg::*;

    localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MQW   = PIX_W;
    localparam int TQW   = THR_W;
    localparam int TNW   = PROD_W - 8;
    localparam int LAT   = 1 + (MQW + 1) + 4 + (TQW + 1);
    localparam int CNT_W = $clog2(LAT + 1);

    typedef struct packed {
        t_kind            kind;
        logic [PW-1:0]    pos;
        logic             eof;
        logic             fg;
        logic [SUM_W-1:0] s1;
        logic [SQ_W-1:0]  s2;
        logic [PIX_W-1:0] m;
    } t_tag;

    localparam int TW = $bits(t_tag);

    logic [TRN_W-1:0] r_train;
    logic [WGT_W-1:0] r_weight;
    logic [PW-1:0]    r_pos;
    logic [TRN_W-1:0] r_frame;
    logic [CNT_W-1:0] r_busy;
    logic             r_out_vld;
    logic             r_out_fg;
    logic             r_out_eof;

    logic [TRN_W-1:0] n_eff;
    t_kind            n_kind;
    logic             adv;
    logic             accept;

    always_comb begin
        if (r_train == '0) begin
            n_eff = TRN_W'(1);
        end else if (32'(r_train) > 32'(MAX_TRAIN)) begin
            n_eff = TRN_W'(MAX_TRAIN);
        end else begin
            n_eff = r_train;
        end
        if (r_frame < n_eff) begin
            n_kind = (r_frame == '0) ? K_FIRST : K_ACC;
        end else if (r_frame == n_eff) begin
            n_kind = K_BUILD;
        end else begin
            n_kind = K_DET;
        end
    end

    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv && !((r_pos == '0) && (r_busy != '0));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_train  <= TRAIN_RST;
            r_weight <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRAIN:  r_train  <= i_cfg_data[TRN_W-1:0];
                CFG_WEIGHT: r_weight <= i_cfg_data[WGT_W-1:0];
                default:    r_train  <= r_train;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_frame <= '0;
        end else if (accept) begin
            if (i_end_of_frame) begin
                r_pos <= '0;
                if (r_frame <= n_eff) begin
                    r_frame <= r_frame + 1'b1;
                end
            end else if (r_pos == PW'(MAX_PIXELS - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // store stage
    logic             b_vld;
    t_kind            b_kind;
    logic [PW-1:0]    b_pos;
    logic [PIX_W-1:0] b_px;
    logic             b_eof;
    logic [SUM_W-1:0] b_sum;
    logic [SQ_W-1:0]  b_sq;
    logic [PIX_W-1:0] b_mean;
    logic [THR_W-1:0] b_thr;
    logic [PIX_W-1:0] b_dif;
    t_tag             b_tag;

    logic             t_vld;
    logic [TQW-1:0]   t_quo;
    logic [TW-1:0]    t_tagv;
    t_tag             t_tg;

    gbs_store #(
        .MAX_PIXELS (MAX_PIXELS),
        .PW         (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (accept),
        .i_kind  (n_kind),
        .i_pos   (r_pos),
        .i_px    (i_pixel),
        .i_eof   (i_end_of_frame),
        .i_mwe   (t_vld && (t_tg.kind == K_BUILD)),
        .i_mpos  (t_tg.pos),
        .i_mean  (t_tg.m),
        .i_thr   (t_quo),
        .o_vld   (b_vld),
        .o_kind  (b_kind),
        .o_pos   (b_pos),
        .o_px    (b_px),
        .o_eof   (b_eof),
        .o_sum   (b_sum),
        .o_sq    (b_sq),
        .o_mean  (b_mean),
        .o_thr   (b_thr)
    );

    assign b_dif = (b_px > b_mean) ? b_px - b_mean : b_mean - b_px;

    always_comb begin
        b_tag      = '0;
        b_tag.kind = b_kind;
        b_tag.pos  = b_pos;
        b_tag.eof  = b_eof;
        b_tag.fg   = THR_W'(b_dif) > b_thr;
        b_tag.s1   = b_sum;
        b_tag.s2   = b_sq;
    end

    // mean = S1 / N
    logic           m_vld;
    logic [MQW-1:0] m_quo;
    logic [TW-1:0]  m_tagv;
    t_tag           m_tg;

    gbs_div #(
        .NW (SUM_W),
        .DW (TRN_W),
        .QW (MQW),
        .TW (TW)
    ) u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (b_vld),
        .i_num   (b_sum),
        .i_den   (n_eff),
        .i_tag   (b_tag),
        .o_vld   (m_vld),
        .o_quo   (m_quo),
        .o_tag   (m_tagv)
    );

    always_comb begin
        m_tg   = t_tag'(m_tagv);
        m_tg.m = m_quo;
    end

    // variance about the mean
    logic               r_c_vld;
    t_tag               r_c_tg;
    logic [2*PIX_W-1:0] r_c_mm;
    logic [SQ_W-1:0]    r_c_ms;
    logic               r_d_vld;
    t_tag               r_d_tg;
    logic [VAR_W-1:0]   r_d_nmm;
    logic [VAR_W-1:0]   r_d_ms2;
    logic               r_e_vld;
    t_tag               r_e_tg;
    logic [VAR_W-1:0]   r_e_v;
    logic               r_f_vld;
    t_tag               r_f_tg;
    logic [PROD_W-1:0]  r_f_p;

    logic signed [VAR_W+1:0] n_v;

    assign n_v = $signed({2'b00, r_d_tg.s2, 1'b0}) - $signed({1'b0, r_d_ms2, 1'b0})
               + $signed({1'b0, r_d_nmm, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= m_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_tg  <= m_tg;
            r_c_mm  <= m_tg.m * m_tg.m;
            r_c_ms  <= m_tg.m * m_tg.s1;
            r_d_tg  <= r_c_tg;
            r_d_nmm <= VAR_W'(n_eff) * VAR_W'(r_c_mm);
            r_d_ms2 <= {r_c_ms, 1'b0};
            r_e_tg  <= r_d_tg;
            r_e_v   <= n_v[VAR_W+1] ? '0 : n_v[VAR_W:1];
            r_f_tg  <= r_e_tg;
            r_f_p   <= r_weight * r_e_v;
        end
    end

    // threshold = floor(weight * V / 256) / N
    gbs_div #(
        .NW (TNW),
        .DW (TRN_W),
        .QW (TQW),
        .TW (TW)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_f_vld),
        .i_num   (r_f_p[PROD_W-1:8]),
        .i_den   (n_eff),
        .i_tag   (r_f_tg),
        .o_vld   (t_vld),
        .o_quo   (t_quo),
        .o_tag   (t_tagv)
    );

    assign t_tg = t_tag'(t_tagv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            r_busy <= r_busy + CNT_W'(accept && (n_kind != K_DET))
                    - CNT_W'(adv && t_vld && (t_tg.kind != K_DET));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= t_vld && (t_tg.kind == K_DET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_fg  <= t_tg.fg;
            r_out_eof <= t_tg.eof;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_foreground = r_out_fg;
    assign o_frame_end  = r_out_eof;

endmodule

// File: sv/gbs_chk.sv
module gbs_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [gbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [gbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic [gbs_pkg::PIX_W-1:0]      i_pixel,
    input logic                           i_end_of_frame,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic                           o_foreground,
    input logic                           o_frame_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_foreground) && $stable(o_frame_end))
        else $error("output beat changed while stalled");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("not ready or output valid after reset");

endmodule

bind gaussian_background_subtractor gbs_chk u_gbs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_idx      (i_cfg_idx),
    .i_cfg_data     (i_cfg_data),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_pixel        (i_pixel),
    .i_end_of_frame (i_end_of_frame),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_foreground   (o_foreground),
    .o_frame_end    (o_frame_end)
);

// File: dv/tb_gaussian_background_subtractor.sv
`timescale 1ns / 100ps

module tb_gaussian_background_subtractor;
    import gbs_pkg::*;

    localparam int FRAME_MAX = 16;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             eof;
    } t_pixel_beat;

    typedef struct {
        logic foreground;
        logic frame_end;
    } t_fg_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_pixel = '0;
    logic                  i_end_of_frame = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_foreground;
    logic                  o_frame_end;

    gaussian_background_subtractor u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pixel_beat pixel_q[$];
    t_fg_beat    fg_expect_q[$];

    logic [TRN_W-1:0] train_cfg = TRAIN_RST;
    logic [WGT_W-1:0] weight_cfg = WEIGHT_RST;
    logic [17:0]      pos_cnt = '0;
    logic [TRN_W-1:0] frame_cnt = '0;
    logic [SUM_W-1:0] sum_mem[FRAME_MAX];
    logic [SQ_W-1:0]  sq_mem[FRAME_MAX];
    logic [PIX_W-1:0] mean_mem[FRAME_MAX];
    logic [THR_W-1:0] thr_mem[FRAME_MAX];
    logic [PIX_W-1:0] base_px[FRAME_MAX];

    int  errors = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_fg = 0;
    bit  calm = 0;
    int  hold_left = 0;

    // bit-exact model of one accepted pixel
    function automatic void model_pixel(input logic [PIX_W-1:0] px, input logic eof);
        longint n, s1, s2, m, v, th;
        int     p;
        int     dif;
        t_fg_beat r;
        n = train_cfg == 0 ? 1 : (train_cfg > MAX_TRAIN_DEF ? MAX_TRAIN_DEF : train_cfg);
        p = pos_cnt;
        if (frame_cnt < n) begin
            if (frame_cnt == 0) begin
                sum_mem[p] = SUM_W'(px);
                sq_mem[p]  = SQ_W'(px) * SQ_W'(px);
            end else begin
                sum_mem[p] = sum_mem[p] + SUM_W'(px);
                sq_mem[p]  = sq_mem[p] + SQ_W'(px) * SQ_W'(px);
            end
        end else if (frame_cnt == n) begin
            s1 = sum_mem[p];
            s2 = sq_mem[p];
            m  = s1 / n;
            if (m > 255) m = 255;
            v = s2 - 2 * m * s1 + n * m * m;
            if (v < 0) v = 0;
            th = (longint'(weight_cfg) * v) / (256 * n);
            if (th > 262143) th = 262143;
            mean_mem[p] = PIX_W'(m);
            thr_mem[p]  = THR_W'(th);
        end else begin
            dif = int'(px) - int'(mean_mem[p]);
            if (dif < 0) dif = -dif;
            r.foreground = dif > int'(thr_mem[p]);
            r.frame_end  = eof;
            fg_expect_q.insert(fg_expect_q.size(), r);
        end
        if (eof) begin
            pos_cnt = '0;
            if (frame_cnt <= n) frame_cnt = frame_cnt + 1'b1;
        end else begin
            pos_cnt = pos_cnt + 1'b1;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        t_pixel_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                model_pixel(i_pixel, i_end_of_frame);
                n_in++;
            end
            if (!i_valid || o_ready) begin
                if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
                    b = pixel_q.pop_front();
                    i_valid        <= 1'b1;
                    i_pixel        <= b.pixel;
                    i_end_of_frame <= b.eof;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_fg_beat e;
        if (hold_left > 0) hold_left <= hold_left - 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= (hold_left > 1) ? 1'b0 : (calm || $urandom_range(99) >= 29);
            if (o_valid && i_ready) begin
                n_out++;
                n_fg += o_foreground;
                if (fg_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected beat fg=%0d end=%0d",
                                               o_foreground, o_frame_end);
                end else begin
                    e = fg_expect_q.pop_front();
                    if (e.foreground !== o_foreground || e.frame_end !== o_frame_end) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp fg=%0d end=%0d, got fg=%0d end=%0d",
                                     e.foreground, e.frame_end, o_foreground, o_frame_end);
                    end
                end
            end
        end
    end

    task automatic add_frame(input int size, input int spread);
        t_pixel_beat b;
        int v;
        for (int k = 0; k < size; k++) begin
            if ($urandom_range(3) == 0) begin
                v = $urandom_range(255);
            end else begin
                v = int'(base_px[k]) + int'($urandom_range(2 * spread)) - spread;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            b.pixel = PIX_W'(v);
            b.eof   = (k == size - 1);
            pixel_q.insert(pixel_q.size(), b);
        end
    endtask

    task automatic add_detect(input int frames);
        for (int f = 0; f < frames; f++) add_frame($urandom_range(1, FRAME_MAX), 40);
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || i_valid || fg_expect_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        if (idx == CFG_TRAIN) train_cfg = TRN_W'(val);
        else weight_cfg = WGT_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_pixel_beat b;
        for (int k = 0; k < FRAME_MAX; k++) base_px[k] = PIX_W'($urandom_range(255));
        base_px[0] = 8'd0;
        base_px[1] = 8'd255;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single training frame, max weight
        cfg_write(CFG_TRAIN, 1);
        cfg_write(CFG_WEIGHT, 4095);
        add_frame(FRAME_MAX, 10);
        add_frame(FRAME_MAX, 10);
        for (int k = 0; k < 4; k++) begin
            b.pixel = (k % 2) ? 8'd255 : 8'd0;
            b.eof   = (k == 3);
            pixel_q.insert(pixel_q.size(), b);
        end
        b.pixel = 8'd128; b.eof = 1'b1;
        pixel_q.insert(pixel_q.size(), b);
        add_detect(20);
        wait (pixel_q.size() <= 100);
        hold_left <= 300;
        drain();

        // extend training mid-run, zero weight
        cfg_write(CFG_TRAIN, 3);
        cfg_write(CFG_WEIGHT, 0);
        add_frame(FRAME_MAX, 5);
        add_frame(FRAME_MAX, 5);
        add_detect(20);
        drain();

        // oversized training length clamps to the maximum
        cfg_write(CFG_TRAIN, 511);
        cfg_write(CFG_WEIGHT, 307);
        for (int f = 0; f < 252; f++) add_frame(1, 3);
        add_frame(FRAME_MAX, 3);
        add_detect(15);
        drain();

        // zero training length acts as one, first with no idling
        cfg_write(CFG_TRAIN, 0);
        cfg_write(CFG_WEIGHT, $urandom_range(1, 4094));
        calm = 1;
        add_detect(10);
        drain();
        calm = 0;
        add_detect(10);
        drain();

        $display("%0d pixels sent, %0d foreground beats checked (%0d set)", n_in, n_out, n_fg);
        $display("covered training lengths 1, 3, clamped max and zero; weights 0 to 4095");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
